/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL; clk_i and rst_ni are taken from the
// enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define SVGM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition must never be seen outside reset.
`define SVGM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* hw/rtl/svgm_pkg.sv */
// ----------------------------------------------------------------------------
// svgm_pkg
// Types and constants for the state vector gate and measure unit.
// ----------------------------------------------------------------------------
package svgm_pkg;

  localparam int unsigned NUM_QUBITS_DEF = 10;
  localparam int unsigned NUM_GATE_REGS  = 8;
  localparam int unsigned PADDR_W        = 5;

  typedef logic signed [15:0] coef_t;

  localparam coef_t ONE_Q14 = 16'sd16384;

  // gate register indices
  localparam int unsigned G00R = 0;
  localparam int unsigned G00I = 1;
  localparam int unsigned G01R = 2;
  localparam int unsigned G01I = 3;
  localparam int unsigned G10R = 4;
  localparam int unsigned G10I = 5;
  localparam int unsigned G11R = 6;
  localparam int unsigned G11I = 7;

  typedef enum logic [2:0] {
    REQ_RESET   = 3'd0,
    REQ_GATE    = 3'd1,
    REQ_MEASURE = 3'd2,
    REQ_SAMPLE  = 3'd3,
    REQ_READ    = 3'd4
  } req_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RDA,
    ST_RDB,
    ST_MUL,
    ST_ADD,
    ST_WRA,
    ST_WRB,
    ST_TOTAL,
    ST_TGT0,
    ST_TGT1,
    ST_SCAN,
    ST_READ,
    ST_DONE
  } state_e;

  typedef struct packed {
    coef_t re;
    coef_t im;
  } amp_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [3:0]  target_qubit;
    logic [9:0]  amp_index;
    logic [31:0] random_fraction;
  } in_t;

  typedef struct packed {
    logic               status;
    logic [9:0]         outcome_index;
    logic signed [15:0] read_real;
    logic signed [15:0] read_imag;
  } out_t;

  typedef struct packed {
    logic mul_en;
    logic sum_en;
  } dp_ctl_t;

endpackage

/* hw/rtl/svgm_ram.sv */
// ----------------------------------------------------------------------------
// svgm_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module svgm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/svgm_gate_dp.sv */
// ----------------------------------------------------------------------------
// svgm_gate_dp
// 2x2 complex gate on one amplitude pair: product stage, then sum, round and
// saturate stage.
// ----------------------------------------------------------------------------
module svgm_gate_dp (
  input  logic                                              clk_i,
  input  svgm_pkg::dp_ctl_t                                 ctl_i,
  input  svgm_pkg::coef_t [svgm_pkg::NUM_GATE_REGS-1:0]     gate_i,
  input  svgm_pkg::amp_t                                    a_i,
  input  svgm_pkg::amp_t                                    b_i,
  output svgm_pkg::amp_t                                    y0_o,
  output svgm_pkg::amp_t                                    y1_o
);

  logic signed [31:0] prod_q [16];
  svgm_pkg::amp_t     y0_q, y1_q;

  function automatic svgm_pkg::coef_t round_sat(input logic signed [34:0] x);
    logic signed [34:0] s;
    s = (x + 35'sd8192) >>> 14;
    if (s > 35'sd32767) begin
      return 16'sh7fff;
    end else if (s < -35'sd32768) begin
      return 16'sh8000;
    end
    return s[15:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q[0]  <= gate_i[svgm_pkg::G00R] * a_i.re;
      prod_q[1]  <= gate_i[svgm_pkg::G00I] * a_i.im;
      prod_q[2]  <= gate_i[svgm_pkg::G01R] * b_i.re;
      prod_q[3]  <= gate_i[svgm_pkg::G01I] * b_i.im;
      prod_q[4]  <= gate_i[svgm_pkg::G00R] * a_i.im;
      prod_q[5]  <= gate_i[svgm_pkg::G00I] * a_i.re;
      prod_q[6]  <= gate_i[svgm_pkg::G01R] * b_i.im;
      prod_q[7]  <= gate_i[svgm_pkg::G01I] * b_i.re;
      prod_q[8]  <= gate_i[svgm_pkg::G10R] * a_i.re;
      prod_q[9]  <= gate_i[svgm_pkg::G10I] * a_i.im;
      prod_q[10] <= gate_i[svgm_pkg::G11R] * b_i.re;
      prod_q[11] <= gate_i[svgm_pkg::G11I] * b_i.im;
      prod_q[12] <= gate_i[svgm_pkg::G10R] * a_i.im;
      prod_q[13] <= gate_i[svgm_pkg::G10I] * a_i.re;
      prod_q[14] <= gate_i[svgm_pkg::G11R] * b_i.im;
      prod_q[15] <= gate_i[svgm_pkg::G11I] * b_i.re;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.sum_en) begin
      y0_q.re <= round_sat(35'(prod_q[0]) - 35'(prod_q[1]) + 35'(prod_q[2]) - 35'(prod_q[3]));
      y0_q.im <= round_sat(35'(prod_q[4]) + 35'(prod_q[5]) + 35'(prod_q[6]) + 35'(prod_q[7]));
      y1_q.re <= round_sat(35'(prod_q[8]) - 35'(prod_q[9]) + 35'(prod_q[10]) - 35'(prod_q[11]));
      y1_q.im <= round_sat(35'(prod_q[12]) + 35'(prod_q[13]) + 35'(prod_q[14])
                           + 35'(prod_q[15]));
    end
  end

  assign y0_o = y0_q;
  assign y1_o = y1_q;

endmodule

/* hw/rtl/state_vector_gate_and_measure_unit.sv */
// Read: the RAM is read at accept and the data taken in the read state. Reset
// request: clears the memory, one memory write per cycle. Gate: each amplitude
// pair goes through read A, read B, multiply, add, write A and write B, as the
// amplitude RAM has a single read and write port. Measure / sample: total and
// scan passes over the amplitudes, plus a collapse pass for a measure. One item
// at a time. After reset a clearing pass runs with in_stall_o high.
// ----------------------------------------------------------------------------
// state_vector_gate_and_measure_unit
// Amplitude store with reset, single-qubit gate, measure, sample and read requests.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module state_vector_gate_and_measure_unit #(
  parameter int unsigned NUM_QUBITS = svgm_pkg::NUM_QUBITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  svgm_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output svgm_pkg::out_t                out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [svgm_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int unsigned AW   = NUM_QUBITS;
  localparam int unsigned SIZE = 1 << AW;
  localparam int unsigned HALF = SIZE / 2;
  localparam int unsigned TW   = 32 + AW;

  svgm_pkg::state_e state_q, state_d;
  svgm_pkg::coef_t [svgm_pkg::NUM_GATE_REGS-1:0] gate_q;

  logic [AW-1:0]   one_at_q, one_at_d;
  logic [AW:0]     clr_q, clr_d;
  logic            resp_q, resp_d;
  logic [3:0]      tq_q, tq_d;
  logic [AW-1:0]   pair_q, pair_d;
  svgm_pkg::amp_t  a_q, a_d;
  logic [31:0]     frac_q, frac_d;
  logic            meas_q, meas_d;
  logic [AW:0]     iss_q, iss_d;
  logic            v1_q, v1_d, v2_q, v2_d;
  logic [AW-1:0]   idx1_q, idx2_q;
  logic [30:0]     sqr_q, sqi_q;
  logic [TW-1:0]   acc_q, acc_d;
  logic [TW+15:0]  phi_q;
  logic [47:0]     plo_q;
  logic [TW-1:0]   tgt_q, tgt_d;
  svgm_pkg::out_t  res_q, res_d;
  svgm_pkg::out_t  out_q;
  logic            out_valid_q, out_valid_d, out_load;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  svgm_pkg::amp_t  ram_wdata, rd_amp;
  svgm_pkg::amp_t  y0, y1;
  svgm_pkg::dp_ctl_t dp_ctl;

  logic [AW-1:0]   low_mask, step, i0, i1;
  logic            streaming, issuing, in_acc;
  logic [31:0]     prob;
  logic [TW-1:0]   run_new;
  logic [TW+16:0]  tgt_sum;
  logic signed [31:0] sq_re_full, sq_im_full;

  // configuration port
  assign pready = 1'b1;
  assign prdata = {{16{gate_q[paddr[4:2]][15]}}, gate_q[paddr[4:2]]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < int'(svgm_pkg::NUM_GATE_REGS); k++) begin
        gate_q[k] <= (k == int'(svgm_pkg::G00R) || k == int'(svgm_pkg::G11R)) ?
                     svgm_pkg::ONE_Q14 : 16'sd0;
      end
    end else if (psel && penable && pwrite) begin
      gate_q[paddr[4:2]] <= pwdata[15:0];
    end
  end

  svgm_ram #(
    .WIDTH ($bits(svgm_pkg::amp_t)),
    .DEPTH (SIZE)
  ) u_amp_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rd_amp)
  );

  svgm_gate_dp u_gate_dp (
    .clk_i  (clk_i),
    .ctl_i  (dp_ctl),
    .gate_i (gate_q),
    .a_i    (a_q),
    .b_i    (rd_amp),
    .y0_o   (y0),
    .y1_o   (y1)
  );

  // pair addressing: insert a zero at the target bit
  assign low_mask = (AW'(1) << tq_q) - AW'(1);
  assign step     = AW'(1) << tq_q;
  assign i0       = ((pair_q & ~low_mask) << 1) | (pair_q & low_mask);
  assign i1       = i0 | step;

  // probability stream
  assign streaming  = (state_q == svgm_pkg::ST_TOTAL) || (state_q == svgm_pkg::ST_SCAN);
  assign issuing    = !iss_q[AW];
  assign sq_re_full = rd_amp.re * rd_amp.re;
  assign sq_im_full = rd_amp.im * rd_amp.im;
  assign prob       = {1'b0, sqr_q} + {1'b0, sqi_q};
  assign run_new    = acc_q + TW'(prob);
  assign tgt_sum    = (TW+17)'(phi_q) + (TW+17)'(plo_q[47:16]);

  assign in_stall_o = (state_q != svgm_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i) begin
    idx1_q <= iss_q[AW-1:0];
    idx2_q <= idx1_q;
    sqr_q  <= sq_re_full[30:0];
    sqi_q  <= sq_im_full[30:0];
    phi_q  <= acc_q[TW-1:16] * frac_q;
    plo_q  <= acc_q[15:0] * frac_q;
  end

  always_comb begin
    state_d   = state_q;
    one_at_d  = one_at_q;
    clr_d     = clr_q;
    resp_d    = resp_q;
    tq_d      = tq_q;
    pair_d    = pair_q;
    a_d       = a_q;
    frac_d    = frac_q;
    meas_d    = meas_q;
    iss_d     = iss_q;
    acc_d     = acc_q;
    tgt_d     = tgt_q;
    res_d     = res_q;
    out_load  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = clr_q[AW-1:0];
    ram_wdata = '0;
    ram_raddr = AW'(in_data_i.amp_index);
    dp_ctl    = '0;
    v1_d      = streaming && issuing;
    v2_d      = streaming && v1_q;

    case (state_q)
      svgm_pkg::ST_IDLE: begin
        if (in_acc) begin
          res_d = '0;
          case (svgm_pkg::req_e'(in_data_i.req_type))
            svgm_pkg::REQ_RESET: begin
              one_at_d = '0;
              clr_d    = '0;
              resp_d   = 1'b1;
              state_d  = svgm_pkg::ST_CLEAR;
            end
            svgm_pkg::REQ_GATE: begin
              if ({1'b0, in_data_i.target_qubit} >= 5'(NUM_QUBITS)) begin
                res_d.status = 1'b1;
                state_d      = svgm_pkg::ST_DONE;
              end else begin
                tq_d    = in_data_i.target_qubit;
                pair_d  = '0;
                state_d = svgm_pkg::ST_RDA;
              end
            end
            svgm_pkg::REQ_MEASURE, svgm_pkg::REQ_SAMPLE: begin
              meas_d  = (svgm_pkg::req_e'(in_data_i.req_type) == svgm_pkg::REQ_MEASURE);
              frac_d  = in_data_i.random_fraction;
              iss_d   = '0;
              acc_d   = '0;
              state_d = svgm_pkg::ST_TOTAL;
            end
            svgm_pkg::REQ_READ: begin
              state_d = svgm_pkg::ST_READ;
            end
            default: begin
              state_d = svgm_pkg::ST_DONE;
            end
          endcase
        end
      end
      svgm_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q[AW-1:0];
        ram_wdata = (clr_q[AW-1:0] == one_at_q) ? {svgm_pkg::ONE_Q14, 16'sd0} : '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q[AW-1:0] == AW'(SIZE - 1)) begin
          state_d = resp_q ? svgm_pkg::ST_DONE : svgm_pkg::ST_IDLE;
        end
      end
      svgm_pkg::ST_RDA: begin
        ram_raddr = i0;
        state_d   = svgm_pkg::ST_RDB;
      end
      svgm_pkg::ST_RDB: begin
        ram_raddr = i1;
        a_d       = rd_amp;
        state_d   = svgm_pkg::ST_MUL;
      end
      svgm_pkg::ST_MUL: begin
        dp_ctl.mul_en = 1'b1;
        state_d       = svgm_pkg::ST_ADD;
      end
      svgm_pkg::ST_ADD: begin
        dp_ctl.sum_en = 1'b1;
        state_d       = svgm_pkg::ST_WRA;
      end
      svgm_pkg::ST_WRA: begin
        ram_we    = 1'b1;
        ram_waddr = i0;
        ram_wdata = y0;
        state_d   = svgm_pkg::ST_WRB;
      end
      svgm_pkg::ST_WRB: begin
        ram_we    = 1'b1;
        ram_waddr = i1;
        ram_wdata = y1;
        pair_d    = pair_q + 1'b1;
        state_d   = (pair_q == AW'(HALF - 1)) ? svgm_pkg::ST_DONE : svgm_pkg::ST_RDA;
      end
      svgm_pkg::ST_TOTAL: begin
        ram_raddr = iss_q[AW-1:0];
        if (issuing) begin
          iss_d = iss_q + 1'b1;
        end
        if (v2_q) begin
          acc_d = run_new;
        end
        if (!issuing && !v1_q && !v2_q) begin
          state_d = svgm_pkg::ST_TGT0;
        end
      end
      svgm_pkg::ST_TGT0: begin
        state_d = svgm_pkg::ST_TGT1;
      end
      svgm_pkg::ST_TGT1: begin
        tgt_d   = tgt_sum[TW+15:16];
        iss_d   = '0;
        acc_d   = '0;
        state_d = svgm_pkg::ST_SCAN;
      end
      svgm_pkg::ST_SCAN: begin
        ram_raddr = iss_q[AW-1:0];
        if (issuing) begin
          iss_d = iss_q + 1'b1;
        end
        if (v2_q && (run_new >= tgt_q)) begin
          res_d.outcome_index = 10'(idx2_q);
          one_at_d = idx2_q;
          clr_d    = '0;
          resp_d   = 1'b1;
          state_d  = meas_q ? svgm_pkg::ST_CLEAR : svgm_pkg::ST_DONE;
        end else begin
          if (v2_q) begin
            acc_d = run_new;
          end
          // no index reached the target: outcome zero
          if (!issuing && !v1_q && !v2_q) begin
            one_at_d = '0;
            clr_d    = '0;
            resp_d   = 1'b1;
            state_d  = meas_q ? svgm_pkg::ST_CLEAR : svgm_pkg::ST_DONE;
          end
        end
      end
      svgm_pkg::ST_READ: begin
        res_d.read_real = rd_amp.re;
        res_d.read_imag = rd_amp.im;
        state_d         = svgm_pkg::ST_DONE;
      end
      svgm_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = svgm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = svgm_pkg::ST_IDLE;
      end
    endcase

    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= svgm_pkg::ST_CLEAR;
      one_at_q    <= '0;
      clr_q       <= '0;
      resp_q      <= 1'b0;
      iss_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      meas_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      one_at_q    <= one_at_d;
      clr_q       <= clr_d;
      resp_q      <= resp_d;
      iss_q       <= iss_d;
      v1_q        <= v1_d;
      v2_q        <= v2_d;
      meas_q      <= meas_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tq_q   <= tq_d;
    pair_q <= pair_d;
    a_q    <= a_d;
    frac_q <= frac_d;
    acc_q  <= acc_d;
    tgt_q  <= tgt_d;
    res_q  <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SVGM_ASSERT(a_out_from_done, $rose(out_valid_q) |-> $past(state_q == svgm_pkg::ST_DONE), "result beat not from done state")
  `SVGM_ASSERT(a_we_states, ram_we |-> (state_q == svgm_pkg::ST_CLEAR || state_q == svgm_pkg::ST_WRA || state_q == svgm_pkg::ST_WRB), "amplitude write outside a write state")
  `SVGM_ASSERT(a_bad_target, (in_acc && in_data_i.req_type == svgm_pkg::REQ_GATE && {1'b0, in_data_i.target_qubit} >= 5'(NUM_QUBITS)) |=> (state_q == svgm_pkg::ST_DONE && res_q.status), "bad target not flagged")
  `SVGM_ASSERT_NEVER(a_clr_range, state_q == svgm_pkg::ST_CLEAR && clr_q[AW], "clear counter overran")

endmodule
